@@ src/rfm_pkg.sv @@
// Shared types, constants and helper functions for the record FIFO with metadata.
// Used by rfm_ctrl, rfm_dp and record_fifo_with_meta; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rfm_pkg;

   localparam int MAX_SLOTS  = 16;
   localparam int MAX_DATA   = 32;
   localparam int MAX_META   = 8;
   localparam int SLOT_BYTES = MAX_DATA + MAX_META;

   localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int OFF_W   = $clog2(SLOT_BYTES);
   localparam int BYTE_AW = $clog2(MAX_SLOTS * SLOT_BYTES);

   localparam int MODE_W  = 3;
   localparam int VAL_W   = 8;
   localparam int STS_W   = 3;
   localparam int KIND_W  = 2;
   localparam int DLEN_W  = 6;
   localparam int MLEN_W  = 4;
   localparam int CNT_W   = 5;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 6;

   localparam logic [DLEN_W-1:0] DATA_LIMIT_RST = 6'd32;
   localparam logic [MLEN_W-1:0] META_LIMIT_RST = 4'd8;
   localparam logic [CNT_W-1:0]  SLOT_COUNT_RST = 5'd16;

   typedef enum logic [CSR_AW-1:0] {
      CSR_DATA_LIMIT = 2'd0,
      CSR_META_LIMIT = 2'd1,
      CSR_SLOT_COUNT = 2'd2
   } csr_idx_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_DATA   = 3'd0,
      MODE_META   = 3'd1,
      MODE_COMMIT = 3'd2,
      MODE_POP    = 3'd3,
      MODE_READ   = 3'd4,
      MODE_CLEAR  = 3'd5
   } mode_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 3'd0,
      STS_FULL  = 3'd1,
      STS_DLONG = 3'd2,
      STS_MLONG = 3'd3,
      STS_EMPTY = 3'd4
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HDR  = 2'd0,
      KIND_DATA = 2'd1,
      KIND_META = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      VIEW_ACK  = 2'd0,
      VIEW_HDR  = 2'd1,
      VIEW_BYTE = 2'd2
   } view_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COPY,
      S_COPY_END,
      S_ACK,
      S_HDR,
      S_BYTE
   } state_type;

   typedef struct packed {
      logic       stage_data;
      logic       stage_meta;
      logic       commit_reject;
      logic       commit_start;
      logic       copy_step;
      logic       commit_done;
      logic       pop;
      logic       clear;
      logic       ack_ld;
      status_type ack_status;
      logic       hd_start;
      logic       hd_step;
      view_type   view;
   } ctl_cmd_type;

   typedef struct packed {
      status_type commit_status;
      logic       stage_none;
      logic       empty;
      logic       copy_last;
      logic       hd_last;
      logic       byte_last;
   } dp_sts_type;

   // offset of the first stored byte of a record, data region first
   function automatic logic [OFF_W-1:0] first_off(input logic [DLEN_W-1:0] dl);
      logic [OFF_W-1:0] r;
      r = (dl != '0) ? '0 : OFF_W'(MAX_DATA);
      return r;
   endfunction

   function automatic logic has_next(input logic [OFF_W-1:0]  off,
                                     input logic [DLEN_W-1:0] dl,
                                     input logic [MLEN_W-1:0] ml);
      logic r;
      if (int'(off) < MAX_DATA) begin
         r = (int'(off) + 1 < int'(dl)) || (ml != '0);
      end else begin
         r = (int'(off) - MAX_DATA + 1 < int'(ml));
      end
      return r;
   endfunction

   function automatic logic [OFF_W-1:0] next_off(input logic [OFF_W-1:0]  off,
                                                 input logic [DLEN_W-1:0] dl);
      logic [OFF_W-1:0] r;
      if ((int'(off) < MAX_DATA) && (int'(off) + 1 >= int'(dl))) begin
         r = OFF_W'(MAX_DATA);
      end else begin
         r = OFF_W'(int'(off) + 1);
      end
      return r;
   endfunction

   function automatic logic [BYTE_AW-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [OFF_W-1:0]  off);
      return BYTE_AW'(int'(s) * SLOT_BYTES + int'(off));
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0]  eff);
      logic [SLOT_W-1:0] r;
      if (int'(s) + 1 >= int'(eff)) begin
         r = '0;
      end else begin
         r = SLOT_W'(int'(s) + 1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/rfm_ctrl.sv @@
// Request sequencer for the record FIFO: decodes requests and steps commits and head reads.
// Depends on rfm_pkg; drives rfm_dp through ctl_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module rfm_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [rfm_pkg::MODE_W-1:0]  req_mode,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire rfm_pkg::dp_sts_type         sts,
   output rfm_pkg::ctl_cmd_type             cmd
);
   import rfm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.ack_status = STS_OK;
      cmd.view       = VIEW_ACK;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_mode)
                  MODE_DATA: cmd.stage_data = 1'b1;
                  MODE_META: cmd.stage_meta = 1'b1;
                  MODE_COMMIT: begin
                     cmd.ack_ld     = 1'b1;
                     cmd.ack_status = sts.commit_status;
                     if (sts.commit_status != STS_OK) begin
                        cmd.commit_reject = 1'b1;
                        state_in          = S_ACK;
                     end else if (sts.stage_none) begin
                        cmd.commit_done = 1'b1;
                        state_in        = S_ACK;
                     end else begin
                        cmd.commit_start = 1'b1;
                        state_in         = S_COPY;
                     end
                  end
                  MODE_POP: begin
                     cmd.ack_ld = 1'b1;
                     if (sts.empty) begin
                        cmd.ack_status = STS_EMPTY;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                     state_in = S_ACK;
                  end
                  MODE_READ: begin
                     if (sts.empty) begin
                        cmd.ack_ld     = 1'b1;
                        cmd.ack_status = STS_EMPTY;
                        state_in       = S_ACK;
                     end else begin
                        state_in = S_HDR;
                     end
                  end
                  MODE_CLEAR: begin
                     cmd.clear  = 1'b1;
                     cmd.ack_ld = 1'b1;
                     state_in   = S_ACK;
                  end
                  default: ;
               endcase
            end
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (sts.copy_last) begin
               state_in = S_COPY_END;
            end
         end
         S_COPY_END: begin
            cmd.commit_done = 1'b1;
            state_in        = S_ACK;
         end
         S_ACK: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         S_HDR: begin
            rsp_valid = 1'b1;
            cmd.view  = VIEW_HDR;
            if (!rsp_stall) begin
               if (sts.hd_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.hd_start = 1'b1;
                  state_in     = S_BYTE;
               end
            end
         end
         S_BYTE: begin
            rsp_valid = 1'b1;
            cmd.view  = VIEW_BYTE;
            if (!rsp_stall) begin
               if (sts.byte_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.hd_step = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("request taken while a response is pending");

   a_copy_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY && sts.copy_last) |=> state_ff == S_COPY_END)
      else $error("copy did not finish after its last byte");

   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACK && !rsp_stall) |=> state_ff == S_IDLE)
      else $error("acknowledge taken but sequencer not idle");

endmodule

`default_nettype wire

@@ src/rfm_dp.sv @@
// Datapath of the record FIFO: limit registers, staging buffer, slot byte store and pointers.
// Depends on rfm_pkg; commanded by rfm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module rfm_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [rfm_pkg::VAL_W-1:0]   req_value,
   input  wire logic                        csr_valid,
   input  wire logic [rfm_pkg::CSR_AW-1:0]  csr_index,
   input  wire logic [rfm_pkg::CSR_DW-1:0]  csr_wdata,
   input  wire rfm_pkg::ctl_cmd_type        cmd,
   output rfm_pkg::dp_sts_type              sts,
   output logic [rfm_pkg::STS_W-1:0]        rsp_status,
   output logic [rfm_pkg::KIND_W-1:0]       rsp_kind,
   output logic [rfm_pkg::VAL_W-1:0]        rsp_value_res,
   output logic [rfm_pkg::DLEN_W-1:0]       rsp_data_length,
   output logic [rfm_pkg::MLEN_W-1:0]       rsp_meta_length,
   output logic [rfm_pkg::CNT_W-1:0]        rsp_count,
   output logic                             rsp_empty_res,
   output logic                             rsp_full_res,
   output logic                             rsp_last
);
   import rfm_pkg::*;

   logic [DLEN_W-1:0] data_limit_ff;
   logic [MLEN_W-1:0] meta_limit_ff;
   logic [CNT_W-1:0]  slot_count_ff;
   logic [SLOT_W-1:0] rd_slot_ff, wr_slot_ff;
   logic [CNT_W-1:0]  rec_cnt_ff;
   logic [DLEN_W-1:0] sdc_ff;
   logic [MLEN_W-1:0] smc_ff;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic              wr_pend_ff;
   logic [BYTE_AW-1:0] waddr_ff;
   logic [VAL_W-1:0]  stage_rd_ff;
   logic [VAL_W-1:0]  byte_rd_ff;
   status_type        ack_sts_ff;

   logic [VAL_W-1:0]  stage_mem [SLOT_BYTES];
   logic [VAL_W-1:0]  byte_mem  [MAX_SLOTS * SLOT_BYTES];
   logic [DLEN_W-1:0] sdl_mem   [MAX_SLOTS];
   logic [MLEN_W-1:0] sml_mem   [MAX_SLOTS];

   logic [DLEN_W-1:0] dlim;
   logic [MLEN_W-1:0] mlim;
   logic [CNT_W-1:0]  eff_slots;
   logic              full;
   logic [DLEN_W-1:0] hd_dl;
   logic [MLEN_W-1:0] hd_ml;
   logic              stage_we;
   logic [OFF_W-1:0]  stage_waddr;
   logic              csr_slot_wr;

   assign dlim = (int'(data_limit_ff) > MAX_DATA) ? DLEN_W'(MAX_DATA) : data_limit_ff;
   assign mlim = (int'(meta_limit_ff) > MAX_META) ? MLEN_W'(MAX_META) : meta_limit_ff;

   always_comb begin
      if (slot_count_ff == '0) begin
         eff_slots = CNT_W'(1);
      end else if (int'(slot_count_ff) > MAX_SLOTS) begin
         eff_slots = CNT_W'(MAX_SLOTS);
      end else begin
         eff_slots = slot_count_ff;
      end
   end

   assign full  = (rec_cnt_ff >= eff_slots);
   assign hd_dl = sdl_mem[rd_slot_ff];
   assign hd_ml = sml_mem[rd_slot_ff];

   // limit registers
   assign csr_slot_wr = csr_valid && (csr_index == CSR_SLOT_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         data_limit_ff <= DATA_LIMIT_RST;
         meta_limit_ff <= META_LIMIT_RST;
         slot_count_ff <= SLOT_COUNT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DATA_LIMIT: data_limit_ff <= csr_wdata[DLEN_W-1:0];
            CSR_META_LIMIT: meta_limit_ff <= csr_wdata[MLEN_W-1:0];
            CSR_SLOT_COUNT: slot_count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // queue pointers and staged counts
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_slot_ff <= '0;
         wr_slot_ff <= '0;
         rec_cnt_ff <= '0;
         sdc_ff     <= '0;
         smc_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.copy_step;
         if (cmd.stage_data && (int'(sdc_ff) <= MAX_DATA)) begin
            sdc_ff <= sdc_ff + 1'b1;
         end
         if (cmd.stage_meta && (int'(smc_ff) <= MAX_META)) begin
            smc_ff <= smc_ff + 1'b1;
         end
         if (cmd.commit_reject || cmd.commit_done) begin
            sdc_ff <= '0;
            smc_ff <= '0;
         end
         if (cmd.clear || csr_slot_wr) begin
            rd_slot_ff <= '0;
            wr_slot_ff <= '0;
            rec_cnt_ff <= '0;
         end else if (cmd.commit_done) begin
            wr_slot_ff <= next_slot(wr_slot_ff, eff_slots);
            rec_cnt_ff <= rec_cnt_ff + 1'b1;
         end else if (cmd.pop) begin
            rd_slot_ff <= next_slot(rd_slot_ff, eff_slots);
            rec_cnt_ff <= rec_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_done) begin
         sdl_mem[wr_slot_ff] <= sdc_ff;
         sml_mem[wr_slot_ff] <= smc_ff;
      end
      if (cmd.ack_ld) begin
         ack_sts_ff <= cmd.ack_status;
      end
   end

   // byte offset walk, shared by commit copy and head read
   always_comb begin
      if (cmd.commit_start) begin
         off_in = first_off(sdc_ff);
      end else if (cmd.copy_step) begin
         off_in = next_off(off_ff, sdc_ff);
      end else if (cmd.hd_start) begin
         off_in = first_off(hd_dl);
      end else if (cmd.hd_step) begin
         off_in = next_off(off_ff, hd_dl);
      end else begin
         off_in = off_ff;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
   end

   // staging buffer
   assign stage_we    = (cmd.stage_data && (int'(sdc_ff) < MAX_DATA)) ||
                        (cmd.stage_meta && (int'(smc_ff) < MAX_META));
   assign stage_waddr = cmd.stage_data ? OFF_W'(sdc_ff) : OFF_W'(MAX_DATA + int'(smc_ff));

   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_mem[stage_waddr] <= req_value;
      end
      if (cmd.copy_step) begin
         stage_rd_ff <= stage_mem[off_ff];
         waddr_ff    <= byte_addr(wr_slot_ff, off_ff);
      end
   end

   // slot byte store
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         byte_mem[waddr_ff] <= stage_rd_ff;
      end
      if (cmd.hd_start || cmd.hd_step) begin
         byte_rd_ff <= byte_mem[byte_addr(rd_slot_ff, off_in)];
      end
   end

   // status to the sequencer
   always_comb begin
      if (full) begin
         sts.commit_status = STS_FULL;
      end else if (sdc_ff > dlim) begin
         sts.commit_status = STS_DLONG;
      end else if (smc_ff > mlim) begin
         sts.commit_status = STS_MLONG;
      end else begin
         sts.commit_status = STS_OK;
      end
      sts.stage_none = (sdc_ff == '0) && (smc_ff == '0);
      sts.empty      = (rec_cnt_ff == '0);
      sts.copy_last  = !has_next(off_ff, sdc_ff, smc_ff);
      sts.hd_last    = (hd_dl == '0) && (hd_ml == '0);
      sts.byte_last  = !has_next(off_ff, hd_dl, hd_ml);
   end

   // response payload
   always_comb begin
      rsp_status      = STS_OK;
      rsp_kind        = KIND_HDR;
      rsp_value_res   = '0;
      rsp_data_length = '0;
      rsp_meta_length = '0;
      rsp_last        = 1'b1;
      case (cmd.view)
         VIEW_ACK: rsp_status = ack_sts_ff;
         VIEW_HDR: begin
            rsp_data_length = hd_dl;
            rsp_meta_length = hd_ml;
            rsp_last        = (hd_dl == '0) && (hd_ml == '0);
         end
         VIEW_BYTE: begin
            rsp_kind      = (int'(off_ff) < MAX_DATA) ? KIND_DATA : KIND_META;
            rsp_value_res = byte_rd_ff;
            rsp_last      = !has_next(off_ff, hd_dl, hd_ml);
         end
         default: ;
      endcase
   end

   assign rsp_count     = rec_cnt_ff;
   assign rsp_empty_res = (rec_cnt_ff == '0);
   assign rsp_full_res  = full;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rec_cnt_ff <= eff_slots)
      else $error("record count above slot count");

   a_stage_bound: assert property (@(posedge clock) disable iff (reset)
      (int'(sdc_ff) <= MAX_DATA + 1) && (int'(smc_ff) <= MAX_META + 1))
      else $error("staged count beyond saturation");

   a_wr_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_step |=> wr_pend_ff)
      else $error("copy read not followed by store write");

endmodule

`default_nettype wire

@@ src/record_fifo_with_meta.sv @@
// Top level of the record FIFO with metadata: sequencer plus datapath.
// Depends on rfm_pkg, rfm_ctrl and rfm_dp.
//
// Circular queue of up to 16 record slots, each holding up to 32 data bytes and
// 8 metadata bytes. Data and meta bytes are staged one request per cycle and produce
// no response. Pop, clear and rejected commits each give one acknowledge.
// An accepted commit copies the staged bytes into the slot store one byte per cycle
// through the single write port and then gives one acknowledge; an empty record is
// committed without a copy step and is acknowledged the same way.
// A head read gives a header and then one stored byte per cycle while rsp_stall is low.
// One request is worked on at a time; req_stall stays high until its last response is
// taken. Limit registers are written through the csr_ port, which is always ready;
// writing slot_count empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module record_fifo_with_meta (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [rfm_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [rfm_pkg::VAL_W-1:0]   req_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [rfm_pkg::STS_W-1:0]        rsp_status,
   output logic [rfm_pkg::KIND_W-1:0]       rsp_kind,
   output logic [rfm_pkg::VAL_W-1:0]        rsp_value_res,
   output logic [rfm_pkg::DLEN_W-1:0]       rsp_data_length,
   output logic [rfm_pkg::MLEN_W-1:0]       rsp_meta_length,
   output logic [rfm_pkg::CNT_W-1:0]        rsp_count,
   output logic                             rsp_empty_res,
   output logic                             rsp_full_res,
   output logic                             rsp_last,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [rfm_pkg::CSR_AW-1:0]  csr_index,
   input  wire logic [rfm_pkg::CSR_DW-1:0]  csr_wdata
);
   import rfm_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   assign csr_ready = 1'b1;

   rfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_kind        (rsp_kind),
      .rsp_value_res   (rsp_value_res),
      .rsp_data_length (rsp_data_length),
      .rsp_meta_length (rsp_meta_length),
      .rsp_count       (rsp_count),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_full_res    (rsp_full_res),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
